/* hdl/sbrt_pkg.sv */
// Shared types and constants for the sorted breakpoint range table.
// Holds request/response payloads, codes and controller/datapath interface structs.
// No dependencies.
`default_nettype none
package sbrt_pkg;

	localparam int ADDR_W = 20;
	localparam int LEN_W  = 4;

	// request kinds
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_CHECK = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// add status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_DUP  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  length;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       hit;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADD_RD,
		ST_ADD_CMP,
		ST_ADD_END,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS,
		ST_CHK_RD,
		ST_CHK_CMP,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic scan_inc;
		logic sh_init;
		logic rd_cur;
		logic rd_sh;
		logic sh_wr;
		logic ins_wr;
		logic cur_inc;
		logic tbl_clear;
		logic rsp_load;
		rsp_t rsp;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       ptr_end;
		logic       cur_end;
		logic       rd_lt;
		logic       rd_eq;
		logic       rd_in;
		logic       full;
		logic       sh_done;
		logic       rsp_busy;
	} stat_t;

endpackage
`default_nettype wire

/* hdl/sbrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sbrt_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hdl/sbrt_ctrl.sv */
// Controller state machine for the sorted breakpoint range table.
// Depends on sbrt_pkg; drives commands to sbrt_dp and reads its status.
`default_nettype none
module sbrt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sbrt_pkg::stat_t st,
	output sbrt_pkg::cmd_t     cmd
);
	import sbrt_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] status_q, status_d;
	logic       hit_q, hit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= STAT_OK;
			hit_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			hit_q    <= hit_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		hit_d      = hit_q;
		cmd        = '0;
		cmd.rsp    = '{status: status_q, hit: hit_q};
		req_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				status_d = STAT_OK;
				hit_d    = 1'b0;
				unique case (st.kind)
					KIND_ADD:   state_d = ST_ADD_RD;
					KIND_CHECK: state_d = ST_CHK_RD;
					KIND_CLEAR: begin
						cmd.tbl_clear = 1'b1;
						state_d       = ST_RESP;
					end
					default:    state_d = ST_RESP;
				endcase
			end
			// insert position search: first entry not below the address
			ST_ADD_RD: begin
				if (st.ptr_end) begin
					state_d = ST_ADD_END;
				end else begin
					state_d = ST_ADD_CMP;
				end
			end
			ST_ADD_CMP: begin
				if (st.rd_lt) begin
					cmd.scan_inc = 1'b1;
					state_d      = ST_ADD_RD;
				end else if (st.rd_eq) begin
					status_d = STAT_DUP;
					state_d  = ST_RESP;
				end else begin
					state_d = ST_ADD_END;
				end
			end
			ST_ADD_END: begin
				if (st.full) begin
					status_d = STAT_FULL;
					state_d  = ST_RESP;
				end else begin
					cmd.sh_init = 1'b1;
					state_d     = ST_SH_RD;
				end
			end
			// move entries up from the top down to the insert position
			ST_SH_RD: begin
				if (st.sh_done) begin
					state_d = ST_INS;
				end else begin
					cmd.rd_sh = 1'b1;
					state_d   = ST_SH_WR;
				end
			end
			ST_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = ST_SH_RD;
			end
			ST_INS: begin
				cmd.ins_wr = 1'b1;
				status_d   = STAT_OK;
				state_d    = ST_RESP;
			end
			ST_CHK_RD: begin
				if (st.cur_end) begin
					state_d = ST_RESP;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = ST_CHK_CMP;
				end
			end
			ST_CHK_CMP: begin
				if (st.rd_lt) begin
					cmd.cur_inc = 1'b1;
					state_d     = ST_CHK_RD;
				end else if (st.rd_in) begin
					cmd.cur_inc = 1'b1;
					hit_d       = 1'b1;
					state_d     = ST_RESP;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!st.rsp_busy) begin
					cmd.rsp_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/sbrt_dp.sv */
// Datapath for the sorted breakpoint range table: request register, pointers,
// entry RAM, comparators and response register. Depends on sbrt_pkg, sbrt_ram.
`default_nettype none
module sbrt_dp #(
	parameter int MAX_BREAKPOINTS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sbrt_pkg::req_t req_data,
	input  wire sbrt_pkg::cmd_t cmd,
	output sbrt_pkg::stat_t     st,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output sbrt_pkg::rsp_t      rsp_data
);
	import sbrt_pkg::*;

	localparam int IW = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
	localparam int CW = $clog2(MAX_BREAKPOINTS + 1);

	req_t          req_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] sh_q;
	logic [CW-1:0] sh_m1;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cursor_q;
	logic          we;
	logic [IW-1:0] waddr;
	logic [IW-1:0] raddr;
	logic [ADDR_W-1:0] wdata;
	logic [ADDR_W-1:0] rdata;
	logic [ADDR_W:0]   range_end;

	assign sh_m1 = sh_q - CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
		if (cmd.capture) begin
			ptr_q <= '0;
		end else if (cmd.scan_inc) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.sh_init) begin
			sh_q <= count_q;
		end else if (cmd.sh_wr) begin
			sh_q <= sh_m1;
		end
		if (cmd.rsp_load) begin
			rsp_data <= cmd.rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cursor_q  <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cmd.tbl_clear) begin
				count_q  <= '0;
				cursor_q <= '0;
			end else begin
				if (cmd.ins_wr) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.cur_inc) begin
					cursor_q <= cursor_q + CW'(1);
				end
			end
			if (cmd.rsp_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		priority if (cmd.rd_sh) begin
			raddr = sh_m1[IW-1:0];
		end else if (cmd.rd_cur) begin
			raddr = cursor_q[IW-1:0];
		end else begin
			raddr = ptr_q[IW-1:0];
		end
	end

	// shift writes the word read in the cycle before; insert writes the new address
	assign we    = cmd.sh_wr | cmd.ins_wr;
	assign waddr = cmd.sh_wr ? sh_q[IW-1:0] : ptr_q[IW-1:0];
	assign wdata = cmd.sh_wr ? rdata : req_q.address;

	sbrt_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(MAX_BREAKPOINTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign range_end = {1'b0, req_q.address} + (ADDR_W + 1)'(req_q.length);

	assign st.kind     = req_q.kind;
	assign st.ptr_end  = (ptr_q >= count_q);
	assign st.cur_end  = (cursor_q >= count_q);
	assign st.rd_lt    = (rdata < req_q.address);
	assign st.rd_eq    = (rdata == req_q.address);
	assign st.rd_in    = ({1'b0, rdata} < range_end);
	assign st.full     = (count_q >= CW'(MAX_BREAKPOINTS));
	assign st.sh_done  = (sh_q == ptr_q);
	assign st.rsp_busy = rsp_valid & ~rsp_ready;

endmodule
`default_nettype wire

/* hdl/sorted_breakpoint_range_table.sv */
// Sorted breakpoint range table: ascending table of unique breakpoint
// addresses with a forward-only check cursor.
// Request channel req_valid/req_ready/req_data (kind, address, length);
// response channel rsp_valid/rsp_ready/rsp_data (status, hit), one response
// per request, in order.
// A request is taken only while the controller is idle; one request is worked
// at a time. An add scans for the first entry not below the address, moves the
// entries above it up one place and writes the new address; a check moves the
// cursor past lower entries and tests the entry it reaches against the range;
// a clear or an unused kind goes straight to the response.
// The response sits in an output register; a new request is accepted while it
// waits, and the controller only stalls when a second response is ready
// before the first has been taken.
// Reset clears the entry count, the cursor and the response valid; the entry
// RAM is not cleared since only entries below the count are ever read.
`default_nettype none
module sorted_breakpoint_range_table #(
	parameter int MAX_BREAKPOINTS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire sbrt_pkg::req_t req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output sbrt_pkg::rsp_t      rsp_data
);
	import sbrt_pkg::*;

	cmd_t  cmd;
	stat_t st;

	sbrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.st       (st),
		.cmd      (cmd)
	);

	sbrt_dp #(
		.MAX_BREAKPOINTS(MAX_BREAKPOINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (cmd),
		.st       (st),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

endmodule
`default_nettype wire

/* tb/sorted_breakpoint_range_table_tb.sv */
// Testbench for sorted_breakpoint_range_table: directed and random add/check/clear/unused-kind requests
// are checked against an in-bench model of the sorted table and its forward-only cursor.
// Depends on hdl/sbrt_pkg.sv and hdl/sorted_breakpoint_range_table.sv.
module sorted_breakpoint_range_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbrt_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1400;
	localparam int CALM_TAIL = 150;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		req_t req;
		bit   idle;
		bit   drain;
	} pend_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	sorted_breakpoint_range_table #(.MAX_BREAKPOINTS(TABLE_DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	always #5 clk = ~clk;

	// model state
	logic [ADDR_W-1:0] bp_table [TABLE_DEPTH];
	int bp_count = 0;
	int bp_cursor = 0;

	pend_req_t req_q[$];
	rsp_t      bp_result_q[$];
	int  n_errors = 0;
	int  n_taken = 0;
	int  n_queued = 0;
	bit  req_taken = 1'b0;
	int  gap_left = 0;
	bit  cur_idle = 1'b0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  idle_phase = 1'b1;

	function automatic rsp_t table_apply(req_t r);
		rsp_t o;
		int pos;
		int i;
		logic [ADDR_W:0] lim;
		o = '0;
		pos = 0;
		lim = {1'b0, r.address} + (ADDR_W + 1)'(r.length);
		case (r.kind)
			KIND_ADD: begin
				while (pos < bp_count && bp_table[pos] < r.address)
					pos++;
				if (pos < bp_count && bp_table[pos] == r.address)
					o.status = STAT_DUP;
				else if (bp_count >= TABLE_DEPTH)
					o.status = STAT_FULL;
				else begin
					for (i = bp_count; i > pos; i--)
						bp_table[i] = bp_table[i-1];
					bp_table[pos] = r.address;
					bp_count++;
					o.status = STAT_OK;
				end
			end
			KIND_CHECK: begin
				while (bp_cursor < bp_count && bp_table[bp_cursor] < r.address)
					bp_cursor++;
				// entry at cursor is >= address here, so only the upper bound matters
				if (bp_cursor < bp_count && {1'b0, bp_table[bp_cursor]} < lim) begin
					o.hit = 1'b1;
					bp_cursor++;
				end
			end
			KIND_CLEAR: begin
				bp_count = 0;
				bp_cursor = 0;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic push_req(input logic [1:0] k, input logic [ADDR_W-1:0] a,
		input logic [LEN_W-1:0] n, input bit drain);
		pend_req_t p;
		p.req.kind = k;
		p.req.address = a;
		p.req.length = n;
		p.idle = idle_phase;
		p.drain = drain;
		req_q.push_back(p);
		n_queued++;
	endtask

	always @(posedge clk) begin : bp_monitor
		rsp_t want;
		if (arst_n) begin
			req_taken <= req_valid && req_ready;
			if (req_valid && req_ready) begin
				bp_result_q.push_back(table_apply(req_data));
				n_taken++;
			end
			if (rsp_valid && rsp_ready) begin
				if (bp_result_q.size() == 0) begin
					$display("%0t: unexpected response status=%0d hit=%0d",
						$time, rsp_data.status, rsp_data.hit);
					n_errors++;
				end else begin
					want = bp_result_q.pop_front();
					if (rsp_data.status !== want.status) begin
						$display("%0t: status mismatch expected=%0d actual=%0d",
							$time, want.status, rsp_data.status);
						n_errors++;
					end
					if (rsp_data.hit !== want.hit) begin
						$display("%0t: hit mismatch expected=%0d actual=%0d",
							$time, want.hit, rsp_data.hit);
						n_errors++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin : req_driver
		pend_req_t nxt;
		if (arst_n && (!req_valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (req_q.size() == 0 || (req_q[0].drain && bp_result_q.size() != 0)) begin
				req_valid <= 1'b0;
			end else begin
				nxt = req_q.pop_front();
				req_data <= nxt.req;
				req_valid <= 1'b1;
				cur_idle <= nxt.idle;
				if (nxt.idle && $urandom_range(0, 2) == 0)
					gap_left <= $urandom_range(1, 13);
			end
		end
	end

	always @(negedge clk) begin : rsp_sink
		int s;
		s = stall_left;
		if (s > 0)
			s--;
		else if (cur_idle && $urandom_range(0, 5) == 0)
			s = $urandom_range(1, 13);
		stall_left <= s;
		rsp_ready <= arst_n && s == 0 && hold_left == 0;
	end

	// one long receiver hold-off so the block backs up into the request side
	always @(negedge clk) begin : rsp_hold
		if (!hold_done && n_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin : run_limit
		#20ms;
		$display("** sorted_breakpoint_range_table: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] first_addr;
		logic [LEN_W-1:0]  n;
		int pick;
		int seq_idx;

		// directed: empty table, address extremes, duplicate, unused kind, cursor cases
		push_req(KIND_CHECK, 20'h00000, 4'hF, 1'b0);
		push_req(KIND_ADD, 20'hFFFFF, 4'hF, 1'b0);
		push_req(KIND_ADD, 20'h00000, 4'h0, 1'b0);
		push_req(KIND_ADD, 20'h00000, 4'h0, 1'b0);
		push_req(KIND_ADD, 20'h80000, 4'h0, 1'b0);
		push_req(KIND_ADD, 20'h12345, 4'hA, 1'b0);
		push_req(KIND_UNUSED, 20'hFFFFF, 4'hF, 1'b0);
		push_req(KIND_CHECK, 20'h00000, 4'h0, 1'b0);
		push_req(KIND_CHECK, 20'h00000, 4'h1, 1'b0);
		push_req(KIND_CHECK, 20'h10000, 4'hF, 1'b0);
		push_req(KIND_CHECK, 20'h12340, 4'h0, 1'b0);
		push_req(KIND_CHECK, 20'h12346, 4'h0, 1'b0);
		push_req(KIND_ADD, 20'h12340, 4'h0, 1'b0);
		push_req(KIND_CHECK, 20'hFFFF0, 4'hF, 1'b0);
		push_req(KIND_CHECK, 20'hFFFF1, 4'hF, 1'b0);
		push_req(KIND_CHECK, 20'h00000, 4'hF, 1'b0);
		push_req(KIND_CLEAR, 20'hFFFFF, 4'hF, 1'b0);
		push_req(KIND_CHECK, 20'h00000, 4'hF, 1'b0);
		push_req(KIND_ADD, 20'h00001, 4'h0, 1'b0);
		push_req(KIND_CHECK, 20'h00000, 4'h1, 1'b0);
		push_req(KIND_CHECK, 20'h00000, 4'h2, 1'b0);

		seq_idx = 0;
		while (n_queued < ITEM_TARGET) begin
			idle_phase = (n_queued < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 19);
			base = ADDR_W'($urandom);
			n = LEN_W'($urandom);
			if (pick < 13) begin
				// fill a small window, then walk the cursor upward through it
				push_req(($urandom_range(0, 2) != 0) ? KIND_CLEAR : KIND_CHECK, base, n,
					seq_idx == 0 || $urandom_range(0, 9) == 0);
				repeat ($urandom_range(1, 12)) begin
					a = base + ADDR_W'($urandom_range(0, 255));
					n = LEN_W'($urandom);
					push_req(KIND_ADD, a, n, 1'b0);
				end
				a = base;
				repeat ($urandom_range(2, 16)) begin
					if ($urandom_range(0, 7) == 0) begin
						first_addr = base + ADDR_W'($urandom_range(0, 255));
						push_req(KIND_ADD, first_addr, n, 1'b0);
					end else begin
						n = LEN_W'($urandom_range(0, 15));
						push_req(KIND_CHECK, a, n, 1'b0);
						a = a + ADDR_W'($urandom_range(0, 24));
					end
				end
			end else if (pick == 13) begin
				// fill the table, then a duplicate and overflow adds against a full table
				push_req(KIND_CLEAR, base, n, 1'($urandom_range(0, 1)));
				first_addr = ADDR_W'($urandom);
				push_req(KIND_ADD, first_addr, n, 1'b0);
				repeat (TABLE_DEPTH + 5) begin
					a = ADDR_W'($urandom);
					push_req(KIND_ADD, a, n, 1'b0);
				end
				push_req(KIND_ADD, first_addr, n, 1'b0);
				repeat ($urandom_range(4, 10)) begin
					a = ADDR_W'($urandom);
					n = LEN_W'($urandom);
					push_req(KIND_CHECK, a, n, 1'b0);
				end
			end else begin
				repeat ($urandom_range(3, 10)) begin
					a = ADDR_W'($urandom);
					n = LEN_W'($urandom);
					push_req(2'($urandom_range(0, 3)), a, n, 1'b0);
				end
			end
			seq_idx++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || req_valid)
			@(posedge clk);
		while (bp_result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && bp_result_q.size() == 0)
			$display("** sorted_breakpoint_range_table: PASSED **");
		else
			$display("** sorted_breakpoint_range_table: FAILED **");
		$finish;
	end

endmodule
